### rtl/core/cap_pkg.sv
package cap_pkg;

  // Default depth of both delay stores.
  localparam int MAX_DELAY_DEF = 4096;

  // Widths fixed by the register map and the sample format.
  localparam int SMP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int DLY_W  = 13;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 3;
  localparam int PRD_W  = 18;  // rounded product, Q1.15 with two guard bits
  localparam int SUM_W  = 19;  // sum of two rounded products

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_DELAY    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIRECT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DELAYED  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FEEDBACK = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUTPUT   = 3'd5;

  // Filter modes. The fourth code behaves as the cascade.
  localparam logic [MODE_W-1:0] MODE_FF      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FB      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CASCADE = 2'd2;

  // Status of the delay-store positions handed to the control logic.
  typedef struct packed {
    logic rd_live;   // the entry being read has been written since reset
    logic wr_fresh;  // the entry being written has never been written
  } cap_pos_t;

  // Q1.15 sample times Q2.14 gain, rounded half up to Q1.15, not saturated.
  function automatic logic signed [PRD_W-1:0] mulr(input logic signed [SMP_W-1:0] s,
                                                   input logic signed [GAIN_W-1:0] g);
    logic signed [31:0] p;
    begin
      p = 32'(s) * 32'(g);
      p = p + 32'sd8192;
      return p[31:14];
    end
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    begin
      if (v > 19'sd32767) begin
        return 16'sh7fff;
      end else if (v < -19'sd32768) begin
        return 16'sh8000;
      end else begin
        return v[SMP_W-1:0];
      end
    end
  endfunction

endpackage

### rtl/core/cap_delay_ram.sv
module cap_delay_ram #(
  parameter int DEPTH = cap_pkg::MAX_DELAY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [cap_pkg::SMP_W-1:0] wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic signed [cap_pkg::SMP_W-1:0] rdata
);

  logic signed [cap_pkg::SMP_W-1:0] mem [DEPTH];
  logic signed [cap_pkg::SMP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/cap_pos_gen.sv
module cap_pos_gen #(
  parameter int MAX_DELAY = cap_pkg::MAX_DELAY_DEF,
  parameter int AW        = $clog2(MAX_DELAY)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cap_pkg::DLY_W-1:0]    delay_len,
  input  logic                         adv,
  output logic [AW-1:0]                rd_addr,
  output logic [AW-1:0]                wr_addr,
  output cap_pkg::cap_pos_t            pos
);

  // Wide enough for the delay register and for twice the depth.
  localparam int MW = (AW + 1 > cap_pkg::DLY_W) ? AW + 1 : cap_pkg::DLY_W;

  logic [AW-1:0] wp_r, wp_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [MW-1:0] m_raw, m_c, wp_e, diff;

  always_comb begin
    m_raw = MW'(delay_len);
    if (m_raw == '0) begin
      m_c = MW'(1);
    end else if (m_raw > MW'(MAX_DELAY)) begin
      m_c = MW'(MAX_DELAY);
    end else begin
      m_c = m_raw;
    end
    wp_e = MW'(wp_r);
    if (wp_e >= m_c) begin
      diff = wp_e - m_c;
    end else begin
      diff = wp_e + MW'(MAX_DELAY) - m_c;
    end
  end

  assign rd_addr = diff[AW-1:0];
  assign wr_addr = wp_r;

  // Until the position first wraps, only the entries below it have been written.
  assign pos.rd_live  = wrapped_r || (rd_addr < wp_r);
  assign pos.wr_fresh = !wrapped_r;

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (adv) begin
      if (wp_r == AW'(MAX_DELAY - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

endmodule

### rtl/core/comb_allpass_filter.sv
// Comb and Schroeder allpass filter. Each request carries one signed Q1.15
// sample and returns one filtered Q1.15 sample, saturated to 16 bits. The
// mode register picks a feedforward comb, a feedback comb or the cascade of
// both (the allpass); gains are Q2.14, products round half up, and both
// stages share one delay M taken from the delay register and clamped to the
// range 1 to MAX_DELAY. From acceptance until its result is loaded into the
// output register, a request passes through the delay-store read together
// with the products on the delayed samples, then the feedback sum with the
// store write-back, then the output-gain product of the feedback comb. The
// block works on one sample at a time, so the next sample is accepted only
// after the previous result has been loaded into the output register. A
// finished result waits in the output register, so the next sample is
// accepted while it is still stalled. The delay stores read as zero after
// reset with no clearing pass; configuration may only be written while no
// request is in flight.
module comb_allpass_filter #(
  parameter int MAX_DELAY = cap_pkg::MAX_DELAY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cap_pkg::SMP_W-1:0]   in_sample,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cap_pkg::SMP_W-1:0]   out_sample,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [cap_pkg::IDX_W-1:0]          cfg_index,
  input  logic [cap_pkg::GAIN_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_DELAY);

  // Sequencer states: wait for a sample, read the stores, mix, finish.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_MIX  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Configuration registers.
  logic [cap_pkg::MODE_W-1:0]        mode_r;
  logic [cap_pkg::DLY_W-1:0]         delay_r;
  logic signed [cap_pkg::GAIN_W-1:0] g0_r, gm_r, ga_r, g1_r;

  // Control.
  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc, out_load, adv;

  // Datapath registers.
  logic signed [cap_pkg::SMP_W-1:0] x_r, w_r, v_r, yff_r, out_sample_r;
  logic signed [cap_pkg::PRD_W-1:0] p0_r, pa_r, pm_r;
  logic                             live_r;

  // Delay-store interface.
  logic [AW-1:0]                    rd_addr, wr_addr;
  cap_pkg::cap_pos_t                pos;
  logic signed [cap_pkg::SMP_W-1:0] ff_q, fb_q, xd, vd;
  logic                             fb_we;
  logic signed [cap_pkg::SMP_W-1:0] fb_wdata;

  // Combinational results of the mix and finish steps.
  logic signed [cap_pkg::SMP_W-1:0] v_mix, yff_mix, y_fin, v_base;

  logic is_ff, is_fb;

  assign is_ff = (mode_r == cap_pkg::MODE_FF);
  assign is_fb = (mode_r == cap_pkg::MODE_FB);

  // Configuration writes. An index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cap_pkg::MODE_CASCADE;
      delay_r <= cap_pkg::DLY_W'(1);
      g0_r    <= 16'sd16384;
      gm_r    <= 16'sd16384;
      ga_r    <= 16'sd0;
      g1_r    <= 16'sd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        cap_pkg::REG_MODE:     mode_r  <= cfg_wdata[cap_pkg::MODE_W-1:0];
        cap_pkg::REG_DELAY:    delay_r <= cfg_wdata[cap_pkg::DLY_W-1:0];
        cap_pkg::REG_DIRECT:   g0_r    <= cfg_wdata;
        cap_pkg::REG_DELAYED:  gm_r    <= cfg_wdata;
        cap_pkg::REG_FEEDBACK: ga_r    <= cfg_wdata;
        cap_pkg::REG_OUTPUT:   g1_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The write position, the read position M samples back, and whether those
  // entries have been written since reset.
  cap_pos_gen #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .delay_len (delay_r),
    .adv       (adv),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .pos       (pos)
  );

  // Past input samples for the feedforward stage.
  cap_delay_ram #(
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_ff_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (wr_addr),
    .wdata (x_r),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ff_q)
  );

  // Past feedback-stage values. In feedforward mode the store is left alone,
  // except that an entry is zeroed the first time the position passes it, so
  // that every entry behind the position holds a defined value.
  cap_delay_ram #(
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_fb_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (wr_addr),
    .wdata (fb_wdata),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (fb_q)
  );

  // The read and the write of one sample are cycles apart and samples do not
  // overlap, so a read always sees the previous sample's write-back.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign adv      = (state_r == ST_MIX);

  // Entries not yet written since reset read as zero.
  assign xd = live_r ? ff_q : '0;
  assign vd = live_r ? fb_q : '0;

  // Feedback sum: the cascade adds to the feedforward output, the plain
  // feedback comb adds to the input sample.
  assign v_base  = is_fb ? x_r : w_r;
  assign v_mix   = cap_pkg::sat16(cap_pkg::SUM_W'(v_base) + cap_pkg::SUM_W'(pa_r));
  assign yff_mix = cap_pkg::sat16(cap_pkg::SUM_W'(p0_r) + cap_pkg::SUM_W'(pm_r));

  assign fb_we    = adv && (!is_ff || pos.wr_fresh);
  assign fb_wdata = is_ff ? '0 : v_mix;

  always_comb begin
    if (is_ff) begin
      y_fin = yff_r;
    end else if (is_fb) begin
      y_fin = cap_pkg::sat16(cap_pkg::SUM_W'(cap_pkg::mulr(v_r, g1_r)));
    end else begin
      y_fin = v_r;
    end
  end

  // The result is loaded once the output register is free or being emptied.
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_MIX;
      ST_MIX: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath. The direct product is taken as the sample arrives, the products
  // on the delayed samples once the stores have answered.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= in_sample;
      p0_r   <= cap_pkg::mulr(in_sample, g0_r);
      live_r <= pos.rd_live;
    end
    if (state_r == ST_RD) begin
      pa_r <= cap_pkg::mulr(vd, ga_r);
      pm_r <= cap_pkg::mulr(xd, gm_r);
      w_r  <= cap_pkg::sat16(cap_pkg::SUM_W'(p0_r) + cap_pkg::SUM_W'(xd));
    end
    if (state_r == ST_MIX) begin
      v_r   <= v_mix;
      yff_r <= yff_mix;
    end
    if (out_load) begin
      out_sample_r <= y_fin;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### rtl/core/cap_checker.sv
module cap_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [cap_pkg::SMP_W-1:0]   out_sample
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  // A waiting result is neither dropped nor changed.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample))
    else $error("stalled result changed");

  // Samples are worked on one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second request accepted while one is in flight");

  // A result needs the read, the delayed products and the mix first.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

  // A new result only follows a request that was being worked on.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

endmodule

bind comb_allpass_filter cap_checker u_cap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample)
);

### dv/comb_allpass_filter_checker.sv
`timescale 1ns / 1ps

module comb_allpass_filter_checker #(
  parameter int DEPTH = cap_pkg::MAX_DELAY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [cap_pkg::SMP_W-1:0] in_sample,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [cap_pkg::SMP_W-1:0] out_sample,
  input  logic                             cfg_we,
  input  logic [cap_pkg::IDX_W-1:0]        cfg_index,
  input  logic [cap_pkg::GAIN_W-1:0]       cfg_wdata,
  output int                               mismatches,
  output int                               outstanding
);

  logic [cap_pkg::MODE_W-1:0]        mode_q;
  logic [cap_pkg::DLY_W-1:0]         delay_q;
  logic signed [cap_pkg::GAIN_W-1:0] g_direct;
  logic signed [cap_pkg::GAIN_W-1:0] g_delayed;
  logic signed [cap_pkg::GAIN_W-1:0] g_feedback;
  logic signed [cap_pkg::GAIN_W-1:0] g_output;

  logic signed [cap_pkg::SMP_W-1:0] ff_hist [DEPTH];
  logic signed [cap_pkg::SMP_W-1:0] fb_hist [DEPTH];
  int                               wr_pos;

  logic signed [cap_pkg::SMP_W-1:0] expected_samples [$];

  // Q1.15 times Q2.14, rounded half up back to Q1.15.
  function automatic longint scale_q15(input longint s, input longint g);
    return (s * g + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic logic signed [cap_pkg::SMP_W-1:0] filter_sample(
    input logic signed [cap_pkg::SMP_W-1:0] x);
    int     m;
    int     rd;
    longint xin;
    longint xd;
    longint vd;
    longint w;
    longint v;
    longint y;
    m = int'(delay_q);
    if (m < 1) m = 1;
    if (m > DEPTH) m = DEPTH;
    rd  = (wr_pos + DEPTH - m) % DEPTH;
    xin = x;
    xd  = ff_hist[rd];
    vd  = fb_hist[rd];
    case (mode_q)
      cap_pkg::MODE_FF: begin
        y = clip16(scale_q15(xin, g_direct) + scale_q15(xd, g_delayed));
      end
      cap_pkg::MODE_FB: begin
        v = clip16(xin + scale_q15(vd, g_feedback));
        y = clip16(scale_q15(v, g_output));
        fb_hist[wr_pos] = v[cap_pkg::SMP_W-1:0];
      end
      default: begin
        // Cascade; the spare mode code behaves the same way.
        w = clip16(scale_q15(xin, g_direct) + xd);
        v = clip16(w + scale_q15(vd, g_feedback));
        y = v;
        fb_hist[wr_pos] = v[cap_pkg::SMP_W-1:0];
      end
    endcase
    ff_hist[wr_pos] = x;
    wr_pos = (wr_pos + 1) % DEPTH;
    return y[cap_pkg::SMP_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [cap_pkg::SMP_W-1:0] want;
    if (!rst_n) begin
      mode_q     = cap_pkg::MODE_CASCADE;
      delay_q    = cap_pkg::DLY_W'(1);
      g_direct   = 16'sd16384;
      g_delayed  = 16'sd16384;
      g_feedback = 16'sd0;
      g_output   = 16'sd16384;
      for (int i = 0; i < DEPTH; i++) begin
        ff_hist[i] = '0;
        fb_hist[i] = '0;
      end
      wr_pos = 0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: out_sample %0d arrived with no request outstanding",
                   $time, out_sample);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            $display("%0t: out_sample mismatch, expected %0d, got %0d",
                     $time, want, out_sample);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_samples.push_back(filter_sample(in_sample));
      end
      if (cfg_we) begin
        case (cfg_index)
          cap_pkg::REG_MODE:     mode_q     = cfg_wdata[cap_pkg::MODE_W-1:0];
          cap_pkg::REG_DELAY:    delay_q    = cfg_wdata[cap_pkg::DLY_W-1:0];
          cap_pkg::REG_DIRECT:   g_direct   = cfg_wdata;
          cap_pkg::REG_DELAYED:  g_delayed  = cfg_wdata;
          cap_pkg::REG_FEEDBACK: g_feedback = cfg_wdata;
          cap_pkg::REG_OUTPUT:   g_output   = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

### dv/comb_allpass_filter_tb.sv
`timescale 1ns / 1ps

module comb_allpass_filter_tb;

  // Watchdog on the whole run.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1250;
  // A tail after the final drain, so that any late or extra result still reaches the checker.
  localparam int TAIL_CYCLES  = 20;

  // The fourth mode code is not named in the package; the block treats it as the cascade.
  localparam logic [cap_pkg::MODE_W-1:0] MODE_SPARE   = 2'd3;
  // Indexes past the register map; writes to them must be ignored.
  localparam logic [cap_pkg::IDX_W-1:0]  REG_SPARE_LO = 3'd6;
  localparam logic [cap_pkg::IDX_W-1:0]  REG_SPARE_HI = 3'd7;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [cap_pkg::SMP_W-1:0]  in_sample;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [cap_pkg::SMP_W-1:0]  out_sample;
  logic                              cfg_we;
  logic [cap_pkg::IDX_W-1:0]         cfg_index;
  logic [cap_pkg::GAIN_W-1:0]        cfg_wdata;

  int mismatches;
  int outstanding;
  int cycle_count;
  int sent_count;
  int phase_len;
  int pause_at;

  // When set, the matching side runs a stretch with no idling at all.
  bit in_calm;
  bit out_calm;

  comb_allpass_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // The checker sees the same pins as the block, keeps its own copy of the filter
  // state and reports how many results are still owed.
  comb_allpass_filter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A run that hangs on a handshake ends here as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [cap_pkg::GAIN_W-1:0] random_word();
    int r;
    r = $urandom;
    return r[cap_pkg::GAIN_W-1:0];
  endfunction

  // Samples lean toward full-scale values so that the saturating sums are hit often.
  function automatic logic signed [cap_pkg::SMP_W-1:0] random_sample();
    int r;
    case ($urandom_range(0, 7))
      0:       r = 32767;
      1:       r = -32768;
      2:       r = $urandom_range(0, 255) - 128;
      default: r = $urandom;
    endcase
    return r[cap_pkg::SMP_W-1:0];
  endfunction

  // Gains mix the two extremes, any code at all, and moderate values of magnitude
  // up to one, which keep the feedback loop from sitting in saturation.
  function automatic logic [cap_pkg::GAIN_W-1:0] random_gain();
    int r;
    case ($urandom_range(0, 5))
      0:       r = -32768;
      1:       r = 32767;
      2:       r = $urandom;
      default: r = $urandom_range(0, 32767) - 16384;
    endcase
    return r[cap_pkg::GAIN_W-1:0];
  endfunction

  // Mostly short delays so that the delayed taps carry real history. Zero and
  // values past the store depth check the clamping, and a full random word checks
  // that bits above the delay field are dropped.
  function automatic logic [cap_pkg::GAIN_W-1:0] random_delay();
    int r;
    case ($urandom_range(0, 9))
      0:       r = 0;
      1:       r = cap_pkg::MAX_DELAY_DEF;
      2:       r = $urandom_range(cap_pkg::MAX_DELAY_DEF + 1, 8191);
      3:       r = $urandom;
      4:       r = $urandom_range(17, 400);
      default: r = $urandom_range(1, 16);
    endcase
    return r[cap_pkg::GAIN_W-1:0];
  endfunction

  // Any of the four mode codes, sometimes with junk in the unused upper bits.
  function automatic logic [cap_pkg::GAIN_W-1:0] random_mode();
    int r;
    r = $urandom_range(0, 1) ? $urandom : 0;
    r[cap_pkg::MODE_W-1:0] = cap_pkg::MODE_W'($urandom_range(0, 3));
    return r[cap_pkg::GAIN_W-1:0];
  endfunction

  // One register write, set up on a falling edge and taken on the next rising edge.
  task automatic write_reg(input logic [cap_pkg::IDX_W-1:0] idx,
                           input logic [cap_pkg::GAIN_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Presents one request after a random gap and holds it until the block takes it.
  // With no gap, valid simply stays high into the next request.
  task automatic send_sample(input logic signed [cap_pkg::SMP_W-1:0] x);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Drops valid and waits until every result owed has come out. Each request
  // yields exactly one result, so the block is idle at that point.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // A new random setting between phases. Each register is touched with some chance,
  // and now and then an index past the map is written with junk.
  task automatic reconfigure(input bit all_regs);
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(cap_pkg::REG_MODE, random_mode());
    if (all_regs || $urandom_range(0, 1) != 0) write_reg(cap_pkg::REG_DELAY, random_delay());
    if (all_regs || $urandom_range(0, 1) != 0) write_reg(cap_pkg::REG_DIRECT, random_gain());
    if (all_regs || $urandom_range(0, 1) != 0) write_reg(cap_pkg::REG_DELAYED, random_gain());
    if (all_regs || $urandom_range(0, 1) != 0) write_reg(cap_pkg::REG_FEEDBACK, random_gain());
    if (all_regs || $urandom_range(0, 1) != 0) write_reg(cap_pkg::REG_OUTPUT, random_gain());
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, random_word());
    end
  endtask

  // Result side. For every result it holds stall high for a random number of
  // cycles, then drops it and waits for the result to be taken.
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 9);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    bit first;
    int target;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_sample  = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    sent_count = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First the reset setting: cascade, delay one, unit gains and
    // no feedback. Full-scale pairs saturate the first stage in both directions.
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shffff);
    send_sample(16'sh5555);
    wait_drained();

    // Feedforward comb with a zero delay, which must clamp to one, and the two
    // gain extremes, so both products are at their largest magnitude.
    write_reg(cap_pkg::REG_MODE, cap_pkg::GAIN_W'(cap_pkg::MODE_FF));
    write_reg(cap_pkg::REG_DELAY, 16'h0000);
    write_reg(cap_pkg::REG_DIRECT, 16'h7fff);
    write_reg(cap_pkg::REG_DELAYED, 16'h8000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    wait_drained();

    // Feedback comb at the most negative feedback gain and the largest output gain.
    // The feedforward phase zeroed the unwritten feedback-store entries it passed, so
    // the first read here sees one of those zeros.
    write_reg(cap_pkg::REG_MODE, cap_pkg::GAIN_W'(cap_pkg::MODE_FB));
    write_reg(cap_pkg::REG_DELAY, 16'h0001);
    write_reg(cap_pkg::REG_FEEDBACK, 16'h8000);
    write_reg(cap_pkg::REG_OUTPUT, 16'h7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh4000);
    wait_drained();

    // The spare mode code must act as the cascade. The delay word has every bit
    // set, so the field reads past the store depth and clamps to it. The two
    // writes past the register map must change nothing.
    write_reg(cap_pkg::REG_MODE, cap_pkg::GAIN_W'(MODE_SPARE));
    write_reg(cap_pkg::REG_DELAY, 16'hffff);
    write_reg(cap_pkg::REG_DIRECT, 16'h8000);
    write_reg(cap_pkg::REG_FEEDBACK, 16'h7fff);
    write_reg(REG_SPARE_LO, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    send_sample(16'shedcb);
    wait_drained();

    // Random part, in phases. Each phase runs one setting with its own idling
    // style, and the block is reconfigured only once it has drained.
    reconfigure(1'b1);
    first  = 1'b1;
    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      phase_len = $urandom_range(10, 120);
      in_calm   = ($urandom_range(0, 3) == 0);
      out_calm  = ($urandom_range(0, 3) == 0);
      // The first phase always stops halfway until everything owed is back;
      // later phases do so now and then at a random point.
      if (first) begin
        pause_at = phase_len / 2;
      end else if ($urandom_range(0, 3) == 0) begin
        pause_at = $urandom_range(0, phase_len - 1);
      end else begin
        pause_at = -1;
      end
      for (int i = 0; i < phase_len; i++) begin
        if (i == pause_at) wait_drained();
        send_sample(random_sample());
      end
      wait_drained();
      reconfigure(1'b0);
      first = 1'b0;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### comb_allpass_filter.f
rtl/core/cap_pkg.sv
rtl/core/cap_delay_ram.sv
rtl/core/cap_pos_gen.sv
rtl/core/comb_allpass_filter.sv
rtl/core/cap_checker.sv
dv/comb_allpass_filter_checker.sv
dv/comb_allpass_filter_tb.sv
